### src/lpht_pkg.sv
// Shared types, status codes and hash constants for the linear probe hash table.
// No dependencies; used by every module of the block.
package lpht_pkg;

   localparam logic [63:0] FNV_BASIS = 64'hCBF29CE484222325;

   localparam logic [2:0] ST_FOUND     = 3'd0;
   localparam logic [2:0] ST_MISSING   = 3'd1;
   localparam logic [2:0] ST_INSERTED  = 3'd2;
   localparam logic [2:0] ST_UPDATED   = 3'd3;
   localparam logic [2:0] ST_FULL      = 3'd4;
   localparam logic [2:0] ST_EMPTY_KEY = 3'd5;

   localparam logic KIND_SEARCH = 1'b0;
   localparam logic KIND_SET    = 1'b1;

   typedef struct packed {
      logic        kind;
      logic [63:0] key_head;
      logic [7:0]  key_tail;
      logic [31:0] new_value;
   } req_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [31:0] found_value;
      logic [7:0]  entry_total;
   } rsp_type;

   typedef struct packed {
      logic        is_set;
      logic        empty_key;
      logic [63:0] head;
      logic [7:0]  tail;
      logic [31:0] new_value;
      logic [63:0] hash;
   } job_type;

   // one FNV-1a round; the prime is 2^40 + 0x1B3
   function automatic logic [63:0] fnv_step(input logic [63:0] h, input logic [7:0] b);
      logic [63:0] x;
      x = h ^ {56'd0, b};
      return (x << 40) + (x << 8) + (x << 7) + (x << 5) + (x << 4) + (x << 1) + x;
   endfunction

endpackage

### src/linear_probe_hash_table.sv
// Top level of the linear probe hash table: front hasher, job queue, back prober.
// Depends on lpht_pkg, lpht_front, lpht_queue and lpht_back.
//
//   port group   direction  payload
//   req_         in         lpht_pkg::req_type  kind, key_head, key_tail, new_value
//   rsp_         out        lpht_pkg::rsp_type  status, found_value, entry_total
//
// Front: takes an item, runs one FNV-1a round per key byte (up to 9), then hands the
// job to the queue; req_ready is low from taking an item until the job is handed over.
// Back: takes a job, probes one slot after another through the registered key memory
// read, then loads the result. Front and back overlap through a 2-entry queue.
// After reset the back clears every slot of the key store before taking a job.
// A stalled result holds in the output register while the front keeps hashing.
module linear_probe_hash_table #(
   parameter int CAPACITY    = 256,
   parameter int VALUE_WIDTH = 32
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  lpht_pkg::req_type req_item,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output lpht_pkg::rsp_type rsp_item
);

   logic              f_valid, f_ready;
   lpht_pkg::job_type f_job;
   logic              b_valid, b_ready;
   lpht_pkg::job_type b_job;

   lpht_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_item  (req_item),
      .job_valid (f_valid),
      .job_ready (f_ready),
      .job       (f_job)
   );

   lpht_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (f_valid),
      .push_ready (f_ready),
      .push_job   (f_job),
      .pop_valid  (b_valid),
      .pop_ready  (b_ready),
      .pop_job    (b_job)
   );

   lpht_back #(
      .CAPACITY    (CAPACITY),
      .VALUE_WIDTH (VALUE_WIDTH)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .job_valid (b_valid),
      .job_ready (b_ready),
      .job       (b_job),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_item  (rsp_item)
   );

endmodule

### src/lpht_front.sv
// Front end: accepts requests, trims the key at its first zero byte and hashes it.
// Depends on lpht_pkg; hashes one key byte per cycle.
module lpht_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  lpht_pkg::req_type req_item,
   output logic              job_valid,
   input  logic              job_ready,
   output lpht_pkg::job_type job
);

   logic              busy_ff, busy_in;
   logic [3:0]        len_ff, len_in;
   logic [3:0]        idx_ff, idx_in;
   logic [63:0]       hash_ff, hash_in;
   lpht_pkg::job_type job_ff, job_in;
   logic [71:0]       bytes;
   logic [7:0]        cur_byte;
   logic [63:0]       head_n;
   logic [3:0]        len_n;
   logic              stop;

   assign req_ready = !busy_ff;
   assign job_valid = busy_ff && (idx_ff == len_ff);
   assign bytes     = {job_ff.tail, job_ff.head};

   always_comb begin
      head_n = '0;
      len_n  = '0;
      stop   = 1'b0;
      for (int i = 0; i < 8; i++) begin
         if (!stop && req_item.key_head[8*i +: 8] != 8'd0) begin
            head_n[8*i +: 8] = req_item.key_head[8*i +: 8];
            len_n = len_n + 4'd1;
         end else begin
            stop = 1'b1;
         end
      end
   end

   always_comb begin
      cur_byte = 8'd0;
      for (int i = 0; i < 9; i++) begin
         if (idx_ff == 4'(i)) begin
            cur_byte = bytes[8*i +: 8];
         end
      end
   end

   always_comb begin
      busy_in = busy_ff;
      len_in  = len_ff;
      idx_in  = idx_ff;
      hash_in = hash_ff;
      job_in  = job_ff;
      job     = job_ff;
      job.hash = hash_ff;
      if (!busy_ff) begin
         if (req_valid) begin
            busy_in          = 1'b1;
            idx_in           = '0;
            hash_in          = lpht_pkg::FNV_BASIS;
            job_in.is_set    = (req_item.kind == lpht_pkg::KIND_SET);
            job_in.head      = head_n;
            job_in.new_value = req_item.new_value;
            job_in.hash      = '0;
            job_in.empty_key = (len_n == 4'd0);
            if (len_n == 4'd8 && req_item.key_tail != 8'd0) begin
               job_in.tail = req_item.key_tail;
               len_in      = 4'd9;
            end else begin
               job_in.tail = 8'd0;
               len_in      = len_n;
            end
         end
      end else if (idx_ff != len_ff) begin
         hash_in = lpht_pkg::fnv_step(hash_ff, cur_byte);
         idx_in  = idx_ff + 4'd1;
      end else if (job_ready) begin
         busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
      len_ff  <= len_in;
      idx_ff  <= idx_in;
      hash_ff <= hash_in;
      job_ff  <= job_in;
   end

endmodule

### src/lpht_queue.sv
// Two-entry queue of hashed jobs between the front and back ends.
// Depends on lpht_pkg for the job type.
module lpht_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push_valid,
   output logic              push_ready,
   input  lpht_pkg::job_type push_job,
   output logic              pop_valid,
   input  logic              pop_ready,
   output lpht_pkg::job_type pop_job
);

   lpht_pkg::job_type slot_ff [2];
   logic              wr_ptr_ff, wr_ptr_in;
   logic              rd_ptr_ff, rd_ptr_in;
   logic [1:0]        fill_ff, fill_in;
   logic              do_push, do_pop;

   assign push_ready = (fill_ff != 2'd2);
   assign pop_valid  = (fill_ff != 2'd0);
   assign pop_job    = slot_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ do_push;
      rd_ptr_in = rd_ptr_ff ^ do_pop;
      fill_in   = fill_ff + {1'b0, do_push} - {1'b0, do_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         fill_ff   <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

### src/lpht_back.sv
// Back end: clears the key store after reset, probes, inserts, updates and responds.
// Depends on lpht_pkg; holds the key and value memories and the entry count.
module lpht_back #(
   parameter int CAPACITY    = 256,
   parameter int VALUE_WIDTH = 32
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              job_valid,
   output logic              job_ready,
   input  lpht_pkg::job_type job,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output lpht_pkg::rsp_type rsp_item
);

   localparam int SLOT_W = $clog2(CAPACITY);
   localparam int CNT_W  = $clog2(CAPACITY / 2) + 1;

   localparam logic [1:0] S_CLEAR = 2'd0;
   localparam logic [1:0] S_IDLE  = 2'd1;
   localparam logic [1:0] S_PROBE = 2'd2;
   localparam logic [1:0] S_DONE  = 2'd3;

   logic [71:0]            key_mem [CAPACITY];
   logic [VALUE_WIDTH-1:0] val_mem [CAPACITY];
   logic [71:0]            key_rd_ff;
   logic [VALUE_WIDTH-1:0] val_rd_ff;

   logic [1:0]             state_ff, state_in;
   logic [SLOT_W-1:0]      clr_ff, clr_in;
   logic [SLOT_W-1:0]      slot_ff, slot_in;
   logic [SLOT_W-1:0]      probes_ff, probes_in;
   logic [CNT_W-1:0]       count_ff, count_in;
   lpht_pkg::job_type      job_ff, job_in;
   logic [2:0]             res_status_ff, res_status_in;
   logic [31:0]            res_value_ff, res_value_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   lpht_pkg::rsp_type      rsp_ff, rsp_in;

   logic [SLOT_W-1:0]      rd_addr, wr_addr;
   logic                   key_we, val_we;
   logic [71:0]            key_wd;
   logic [63:0]            nv64, sv64, ov64;
   logic [VALUE_WIDTH-1:0] new_val;
   logic [31:0]            cnt32;
   logic                   occupied, hit, inserting;

   assign nv64      = 64'(job_ff.new_value);
   assign new_val   = nv64[VALUE_WIDTH-1:0];
   assign sv64      = 64'(new_val);
   assign ov64      = 64'(val_rd_ff);
   assign occupied  = (key_rd_ff[7:0] != 8'd0);
   assign hit       = (key_rd_ff == {job_ff.tail, job_ff.head});
   assign inserting = (state_ff == S_PROBE) && !occupied && job_ff.is_set;
   assign cnt32     = 32'(count_ff);
   assign job_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

   always_comb begin
      state_in      = state_ff;
      clr_in        = clr_ff;
      slot_in       = slot_ff;
      probes_in     = probes_ff;
      count_in      = count_ff;
      job_in        = job_ff;
      res_status_in = res_status_ff;
      res_value_in  = res_value_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_in        = rsp_ff;
      rd_addr       = slot_ff;
      wr_addr       = slot_ff;
      key_we        = 1'b0;
      val_we        = 1'b0;
      key_wd        = {job_ff.tail, job_ff.head};
      case (state_ff)
         S_CLEAR: begin
            key_we  = 1'b1;
            key_wd  = '0;
            wr_addr = clr_ff;
            clr_in  = clr_ff + 1'b1;
            if (clr_ff == {SLOT_W{1'b1}}) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (job_valid) begin
               job_in       = job;
               res_value_in = '0;
               if (job.empty_key) begin
                  res_status_in = lpht_pkg::ST_EMPTY_KEY;
                  state_in      = S_DONE;
               end else if (job.is_set && count_ff >= CNT_W'(CAPACITY / 2)) begin
                  res_status_in = lpht_pkg::ST_FULL;
                  state_in      = S_DONE;
               end else begin
                  rd_addr   = job.hash[SLOT_W-1:0];
                  slot_in   = job.hash[SLOT_W-1:0];
                  probes_in = '0;
                  state_in  = S_PROBE;
               end
            end
         end
         S_PROBE: begin
            if (!occupied) begin
               state_in = S_DONE;
               if (job_ff.is_set) begin
                  key_we        = 1'b1;
                  val_we        = 1'b1;
                  count_in      = count_ff + 1'b1;
                  res_status_in = lpht_pkg::ST_INSERTED;
               end else begin
                  res_status_in = lpht_pkg::ST_MISSING;
               end
            end else if (hit) begin
               state_in = S_DONE;
               if (job_ff.is_set) begin
                  val_we        = 1'b1;
                  res_status_in = lpht_pkg::ST_UPDATED;
                  res_value_in  = sv64[31:0];
               end else begin
                  res_status_in = lpht_pkg::ST_FOUND;
                  res_value_in  = ov64[31:0];
               end
            end else if (probes_ff == {SLOT_W{1'b1}}) begin
               state_in      = S_DONE;
               res_status_in = job_ff.is_set ? lpht_pkg::ST_FULL : lpht_pkg::ST_MISSING;
            end else begin
               slot_in   = slot_ff + 1'b1;
               probes_in = probes_ff + 1'b1;
               rd_addr   = slot_ff + 1'b1;
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in       = 1'b1;
               rsp_in.status      = res_status_ff;
               rsp_in.found_value = res_value_ff;
               rsp_in.entry_total = cnt32[7:0];
               state_in           = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (key_we) begin
         key_mem[wr_addr] <= key_wd;
      end
      if (val_we) begin
         val_mem[wr_addr] <= new_val;
      end
      key_rd_ff <= key_mem[rd_addr];
      val_rd_ff <= val_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      slot_ff       <= slot_in;
      probes_ff     <= probes_in;
      job_ff        <= job_in;
      res_status_ff <= res_status_in;
      res_value_ff  <= res_value_in;
      rsp_ff        <= rsp_in;
   end

`ifndef ASSERT_OFF
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(CAPACITY / 2))
      else $error("entry count above half capacity");

   a_no_pop_in_clear: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_CLEAR |-> !job_ready)
      else $error("job taken during key store clear");

   a_insert_counts: assert property (@(posedge clock) disable iff (reset)
      inserting |=> count_ff == $past(count_ff) + 1'b1)
      else $error("insert did not advance count");

   a_done_to_rsp: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_DONE && !rsp_valid_ff |=> rsp_valid_ff && state_ff == S_IDLE)
      else $error("result not delivered to output register");
`endif

endmodule
